>>> src/mcal_pkg.sv
// Shared types and constants for the magnetometer calibrate-and-heading core.
// Holds fixed-point widths, the CORDIC arctangent table and register indexes.
// No dependencies.
package mcal_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;

  localparam int RAW_W  = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;
  localparam int CAL_W  = 20;
  localparam int VEC_W  = 34;
  localparam int ANG_W  = 34;
  localparam int HMUL_W = 50;
  localparam int HSUM_W = 18;
  localparam int HEAD_W = 15;
  localparam int DECL_W = 15;

  localparam logic signed [15:0] FULL_CIRCLE = 16'sd23040;

  localparam logic signed [ANG_W-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_OFFSET_Z    = 3'd2,
    REG_GAIN_X      = 3'd3,
    REG_GAIN_Y      = 3'd4,
    REG_GAIN_Z      = 3'd5,
    REG_DECLINATION = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] cal_x;
    logic signed [RAW_W-1:0] cal_y;
    logic signed [RAW_W-1:0] cal_z;
    logic                    clip;
    logic                    zero;
  } side_t;

endpackage

>>> src/magnetometer_calibrate_heading_core.sv
// Magnetometer calibration and compass heading core, top level.
// Depends on mcal_pkg for widths, the arctangent table and register indexes.
//
// Usage:
//   s_* stream: one raw X/Y/Z sample per transfer. m_* stream: calibrated,
//   saturated X/Y/Z plus heading in 1/64 degree; m_tuser flags saturation.
//   cfg_* channel: register writes (index 0..6), always ready; write only
//   while no sample is in flight.
// Stages: CORDIC_STEPS + 6 register stages (22 at 16 steps): offset subtract,
//   gain multiply, round/saturate, one CORDIC stage per step, angle scale
//   multiply, declination add, wrap.
// Throughput: one sample per cycle while s_tready is high; each stage holds one sample.
// Stall: each stage advances when it is empty or the stage after it
//   advances, so bubbles collapse and s_tready drops only when every stage
//   holds a sample and m_tready is low. Nothing is lost or repeated.
// Reset: all stage valid bits clear, offsets and declination go to 0,
//   gains go to 1.0 (unsigned Q2.14).
module magnetometer_calibrate_heading_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_x[15:0], raw_y[31:16], raw_z[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cal_x, cal_y, cal_z, heading[62:48], zero pad
  output logic [0:0]  m_tuser,   // clipped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mcal_pkg::*;

  localparam int N       = CORDIC_STEPS;
  localparam int ST_CAL  = 2;
  localparam int ST_HMUL = N + 3;
  localparam int ST_HSUM = N + 4;
  localparam int ST_OUT  = N + 5;
  localparam int NS      = N + 6;

  logic signed [RAW_W-1:0]  offset [0:2];
  logic        [RAW_W-1:0]  gain   [0:2];
  logic signed [DECL_W-1:0] declination;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [DIFF_W-1:0] diff [0:2];
  logic signed [PROD_W-1:0] prod [0:2];

  logic signed [VEC_W-1:0] vx   [0:N];
  logic signed [VEC_W-1:0] vy   [0:N];
  logic signed [ANG_W-1:0] vacc [0:N];
  side_t                   side [0:N];

  logic signed [HMUL_W-1:0] hprod;
  side_t                    side_h;
  logic signed [HSUM_W-1:0] hsum;
  side_t                    side_s;
  logic [HEAD_W-1:0]        heading;
  side_t                    side_o;

  logic signed [PROD_W-1:0] rnd [0:2];
  logic signed [CAL_W-1:0]  cal [0:2];
  logic signed [RAW_W-1:0]  sat [0:2];
  logic                     clip_next;
  logic signed [VEC_W-1:0]  x0_next;
  logic signed [VEC_W-1:0]  y0_next;
  logic signed [ANG_W-1:0]  acc0_next;
  logic signed [ANG_W-1:0]  acc_final;
  logic signed [HMUL_W-1:0] hround;
  logic signed [HSUM_W-1:0] wrap_next;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        offset[a] <= '0;
        gain[a]   <= 16'd16384;
      end
      declination <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X:    offset[0] <= signed'(cfg_data);
        REG_OFFSET_Y:    offset[1] <= signed'(cfg_data);
        REG_OFFSET_Z:    offset[2] <= signed'(cfg_data);
        REG_GAIN_X:      gain[0] <= cfg_data;
        REG_GAIN_Y:      gain[1] <= cfg_data;
        REG_GAIN_Z:      gain[2] <= cfg_data;
        REG_DECLINATION: declination <= signed'(cfg_data[DECL_W-1:0]);
        default: ;
      endcase
    end
  end

  // stage advance chain
  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // offset subtract and gain multiply
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (en[0]) begin
        diff[a] <= DIFF_W'(signed'(s_tdata[RAW_W*a +: RAW_W])) - DIFF_W'(offset[a]);
      end
      if (en[1]) begin
        prod[a] <= PROD_W'(diff[a]) * PROD_W'(signed'({1'b0, gain[a]}));
      end
    end
  end

  // round, saturate, CORDIC setup
  always_comb begin
    clip_next = 1'b0;
    for (int a = 0; a < 3; a++) begin
      rnd[a] = prod[a] + PROD_W'(8192);
      cal[a] = rnd[a][PROD_W-1:14];
      if (cal[a] > CAL_W'(32767)) begin
        sat[a]    = 16'sh7FFF;
        clip_next = 1'b1;
      end else if (cal[a] < -CAL_W'(32768)) begin
        sat[a]    = 16'sh8000;
        clip_next = 1'b1;
      end else begin
        sat[a] = cal[a][RAW_W-1:0];
      end
    end
    if (cal[0] < 0) begin
      x0_next   = -VEC_W'(signed'({cal[0], 12'b0}));
      y0_next   = -VEC_W'(signed'({cal[1], 12'b0}));
      acc0_next = ANG_W'(64'sd2147483648);
    end else begin
      x0_next   = VEC_W'(signed'({cal[0], 12'b0}));
      y0_next   = VEC_W'(signed'({cal[1], 12'b0}));
      acc0_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CAL]) begin
      vx[0]         <= x0_next;
      vy[0]         <= y0_next;
      vacc[0]       <= acc0_next;
      side[0].cal_x <= sat[0];
      side[0].cal_y <= sat[1];
      side[0].cal_z <= sat[2];
      side[0].clip  <= clip_next;
      side[0].zero  <= (cal[0] == '0) && (cal[1] == '0);
    end
  end

  // CORDIC vectoring, one micro-rotation per stage
  for (genvar k = 1; k <= N; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en[ST_CAL + k]) begin
        side[k] <= side[k-1];
        if (vy[k-1] >= 0) begin
          vx[k]   <= vx[k-1] + (vy[k-1] >>> (k - 1));
          vy[k]   <= vy[k-1] - (vx[k-1] >>> (k - 1));
          vacc[k] <= vacc[k-1] + ATAN_TURNS[k-1];
        end else begin
          vx[k]   <= vx[k-1] - (vy[k-1] >>> (k - 1));
          vy[k]   <= vy[k-1] + (vx[k-1] >>> (k - 1));
          vacc[k] <= vacc[k-1] - ATAN_TURNS[k-1];
        end
      end
    end
  end

  // angle scale, declination, wrap
  assign acc_final = side[N].zero ? '0 : vacc[N];
  assign hround    = hprod + HMUL_W'(64'sd2147483648);

  always_comb begin
    if (hsum < 0) begin
      wrap_next = hsum + HSUM_W'(FULL_CIRCLE);
    end else if (hsum >= HSUM_W'(FULL_CIRCLE)) begin
      wrap_next = hsum - HSUM_W'(FULL_CIRCLE);
    end else begin
      wrap_next = hsum;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_HMUL]) begin
      hprod  <= HMUL_W'(acc_final) * HMUL_W'(FULL_CIRCLE);
      side_h <= side[N];
    end
    if (en[ST_HSUM]) begin
      hsum   <= hround[HMUL_W-1:32] + HSUM_W'(declination);
      side_s <= side_h;
    end
    if (en[ST_OUT]) begin
      heading <= wrap_next[HEAD_W-1:0];
      side_o  <= side_s;
    end
  end

  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = {1'b0, heading, side_o.cal_z, side_o.cal_y, side_o.cal_x};
  assign m_tuser  = side_o.clip;

  // checks
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> heading < HEAD_W'(23040))
    else $error("heading out of range");

  a_clip_extreme: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && side_o.clip) |->
      (side_o.cal_x == 16'sh7FFF || side_o.cal_x == 16'sh8000 ||
       side_o.cal_y == 16'sh7FFF || side_o.cal_y == 16'sh8000 ||
       side_o.cal_z == 16'sh7FFF || side_o.cal_z == 16'sh8000))
    else $error("clip flag without saturated axis");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && (&vld)))
    else $error("input stalled while pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

>>> bench/testbench.sv
// Self-checking bench for magnetometer_calibrate_heading_core: streams raw X/Y/Z
// samples, predicts calibrated axes, clip flag and CORDIC heading, checks each transfer.
// Depends on mcal_pkg (register indexes) and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcal_pkg::*;

  typedef struct packed {
    logic signed [15:0] cal_x;
    logic signed [15:0] cal_y;
    logic signed [15:0] cal_z;
    logic [14:0]        heading;
    logic               clipped;
  } reading_t;

  localparam int         TURN_64THS = 23040;
  localparam int         STEPS      = 16;
  localparam longint     HALF_TURN  = 64'sd2147483648;
  localparam longint     FULL_TURN  = 64'sd4294967296;
  localparam logic [2:0] REG_NONE   = 3'd7;
  localparam longint     ARCTAN [0:STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  class heading_ledger;
    logic signed [15:0] offset [3];
    logic [15:0]        gain [3];
    logic signed [14:0] decl;
    reading_t           pending_readings [$];
    int                 mismatches;

    function new();
      offset = '{16'sd0, 16'sd0, 16'sd0};
      gain = '{16'd16384, 16'd16384, 16'd16384};
      decl = '0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
        REG_OFFSET_X: offset[0] = data;
        REG_OFFSET_Y: offset[1] = data;
        REG_OFFSET_Z: offset[2] = data;
        REG_GAIN_X: gain[0] = data;
        REG_GAIN_Y: gain[1] = data;
        REG_GAIN_Z: gain[2] = data;
        REG_DECLINATION: decl = data[14:0];
        default: ;
      endcase
    endfunction

    function longint scaled_axis(input logic signed [15:0] raw, input logic signed [15:0] off,
                                 input logic [15:0] g);
      longint d;
      d = longint'(raw) - longint'(off);
      return (d * longint'(g) + 64'sd8192) >>> 14;
    endfunction

    function longint bearing(input longint cx, input longint cy);
      longint x, y, xs, ys, acc;
      if (cx == 0 && cy == 0) return 0;
      x = cx * 4096;
      y = cy * 4096;
      acc = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = HALF_TURN;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          acc += ARCTAN[i];
        end else begin
          x -= ys;
          y += xs;
          acc -= ARCTAN[i];
        end
      end
      return acc;
    endfunction

    function void log_sample(input logic [47:0] raw);
      longint   c [3];
      longint   total, h;
      reading_t r;
      logic [15:0] sat [3];
      r = '0;
      for (int k = 0; k < 3; k++) begin
        c[k] = scaled_axis(raw[16*k +: 16], offset[k], gain[k]);
        if (c[k] > 32767) begin
          sat[k] = 16'h7fff;
          r.clipped = 1'b1;
        end else if (c[k] < -32768) begin
          sat[k] = 16'h8000;
          r.clipped = 1'b1;
        end else begin
          sat[k] = c[k][15:0];
        end
      end
      r.cal_x = sat[0];
      r.cal_y = sat[1];
      r.cal_z = sat[2];
      total = bearing(c[0], c[1]) * TURN_64THS + longint'(decl) * FULL_TURN + HALF_TURN;
      h = (total >>> 32) % TURN_64THS;
      if (h < 0) h += TURN_64THS;
      r.heading = h[14:0];
      pending_readings.push_back(r);
    endfunction

    function void match_reading(input logic [63:0] d, input logic u);
      reading_t want, got;
      got.cal_x = d[15:0];
      got.cal_y = d[31:16];
      got.cal_z = d[47:32];
      got.heading = d[62:48];
      got.clipped = u;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: cal %0d %0d %0d heading %0d clipped %0b",
                   got.cal_x, got.cal_y, got.cal_z, got.heading, got.clipped);
        return;
      end
      want = pending_readings.pop_front();
      if (got.cal_x !== want.cal_x || got.cal_y !== want.cal_y || got.cal_z !== want.cal_z ||
          got.heading !== want.heading || got.clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected cal %0d %0d %0d heading %0d clipped %0b, got cal %0d %0d %0d heading %0d clipped %0b",
                   want.cal_x, want.cal_y, want.cal_z, want.heading, want.clipped,
                   got.cal_x, got.cal_y, got.cal_z, got.heading, got.clipped);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        calm;

  heading_ledger book;

  magnetometer_calibrate_heading_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [47:0] sample_of(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] random_sample();
    logic [47:0] r;
    int          mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (mode < 4)
        r[16*k +: 16] = 16'($urandom);
      else if (mode < 8)
        r[16*k +: 16] = book.offset[k] + 16'($urandom_range(0, 12000)) - 16'd6000;
      else
        r[16*k +: 16] = book.offset[k] + 16'($urandom_range(0, 6)) - 16'd3;
    end
    return r;
  endfunction

  function automatic logic [15:0] random_offset();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4000) - 2000);
  endfunction

  function automatic logic [15:0] random_gain();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(8192, 32768));
  endfunction

  task automatic send_sample(input logic [47:0] raw);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tdata = raw;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    book.log_sample(raw);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    book.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (book.pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic configure_random();
    write_reg(REG_OFFSET_X, random_offset());
    write_reg(REG_OFFSET_Y, random_offset());
    write_reg(REG_OFFSET_Z, random_offset());
    write_reg(REG_GAIN_X, random_gain());
    write_reg(REG_GAIN_Y, random_gain());
    write_reg(REG_GAIN_Z, random_gain());
    if ($urandom_range(0, 4) == 0)
      write_reg(REG_DECLINATION, 16'($urandom));
    else
      write_reg(REG_DECLINATION, 16'($urandom_range(0, 23040) - 11520));
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.match_reading(m_tdata, m_tuser[0]);
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    book = new();
    rst = 1'b1;
    calm = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_sample(sample_of(0, 0, 0));
    send_sample(sample_of(32767, 0, 0));
    send_sample(sample_of(-32768, 0, 0));
    send_sample(sample_of(0, 32767, 0));
    send_sample(sample_of(0, -32768, 0));
    send_sample(sample_of(-1, 0, 0));
    send_sample(sample_of(32767, -1, 0));
    send_sample(sample_of(1, -1, 0));
    send_sample(sample_of(32767, 32767, 32767));
    send_sample(sample_of(-32768, -32768, -32768));
    send_sample(sample_of(-32768, 32767, -1));
    send_sample(sample_of(12345, -23456, 5));
    repeat (95) send_sample(random_sample());
    settle();

    write_reg(REG_OFFSET_X, 16'h8000);
    write_reg(REG_OFFSET_Y, 16'h7fff);
    write_reg(REG_OFFSET_Z, 16'h8000);
    write_reg(REG_GAIN_X, 16'hffff);
    write_reg(REG_GAIN_Y, 16'hffff);
    write_reg(REG_GAIN_Z, 16'hffff);
    write_reg(REG_DECLINATION, 16'h3fff);
    send_sample(sample_of(-32768, 32767, -32768));
    send_sample(sample_of(32767, -32768, 32767));
    send_sample(sample_of(0, 0, 0));
    send_sample(sample_of(-32767, 32766, -32767));
    repeat (90) send_sample(random_sample());
    settle();

    write_reg(REG_OFFSET_X, random_offset());
    write_reg(REG_OFFSET_Y, random_offset());
    write_reg(REG_OFFSET_Z, random_offset());
    write_reg(REG_GAIN_X, 16'd0);
    write_reg(REG_GAIN_Y, 16'd1);
    write_reg(REG_GAIN_Z, 16'd0);
    write_reg(REG_DECLINATION, 16'h4000);
    write_reg(REG_NONE, 16'hffff);
    send_sample(sample_of(0, 0, 0));
    send_sample(sample_of(32767, -32768, 1));
    send_sample(sample_of(-32768, 32767, -1));
    send_sample(sample_of(5, 0, -5));
    repeat (60) send_sample(random_sample());
    settle();

    for (int p = 0; p < 6; p++) begin
      configure_random();
      if (p == 5) calm = 1'b1;
      repeat (95) send_sample(random_sample());
      settle();
    end

    repeat (30) @(negedge clk);
    if (book.mismatches == 0 && book.pending_readings.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
